@@ hdl/fmts_pkg.sv @@
// Shared types and constants for the FM-chip dual timer status block.
`default_nettype none
package fmts_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned AddrW    = 9;
  localparam int unsigned DataW    = 8;
  localparam int unsigned TickW    = 10;
  localparam int unsigned BaseW    = 3;
  localparam int unsigned ElapsedW = 18;
  localparam int unsigned LimitW   = 19;
  localparam int unsigned CfgIdxW  = 2;

  // Item function codes
  localparam logic [FuncW-1:0] FuncWrite = 2'd0;
  localparam logic [FuncW-1:0] FuncRead  = 2'd1;
  localparam logic [FuncW-1:0] FuncTick  = 2'd2;

  // Register numbers handled by the timer block
  localparam logic [AddrW-1:0] RegT1Preset = 9'd2;
  localparam logic [AddrW-1:0] RegT2Preset = 9'd3;
  localparam logic [AddrW-1:0] RegControl  = 9'd4;

  // Control register bits
  localparam int unsigned CtlIrqReset = 7;
  localparam int unsigned CtlT1Mask   = 6;
  localparam int unsigned CtlT2Mask   = 5;
  localparam int unsigned CtlT1Start  = 0;
  localparam int unsigned CtlT2Start  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStatusBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgT1Tick     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgT2Tick     = 2'd2;

  localparam logic [BaseW-1:0] StatusBaseRst = 3'd0;
  localparam logic [TickW-1:0] T1TickRst     = 10'd80;
  localparam logic [TickW-1:0] T2TickRst     = 10'd320;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam logic [8:0]          PresetSpan = 9'd256;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } item_t;

  // Per-cycle command to one timer
  typedef struct packed {
    logic             tick;
    logic             load;
    logic [DataW-1:0] preset;
    logic             set_en;
    logic             en;
  } tmr_cmd_t;

endpackage
`default_nettype wire

@@ hdl/fmts_in_stage.sv @@
// Input register stage holding one accepted item.
`default_nettype none
module fmts_in_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [fmts_pkg::FuncW-1:0] func_i,
  input  wire logic [fmts_pkg::AddrW-1:0] reg_addr_i,
  input  wire logic [fmts_pkg::DataW-1:0] wdata_i,
  input  wire logic                     take_i,
  output logic                          valid_o,
  output fmts_pkg::item_t               item_o
);

  logic            valid_q, valid_d;
  logic            load;
  fmts_pkg::item_t item_q;

  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.func  <= func_i;
      item_q.addr  <= reg_addr_i;
      item_q.wdata <= wdata_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

@@ hdl/fmts_cfg.sv @@
// Configuration registers: status base code and the two tick periods.
`default_nettype none
module fmts_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [fmts_pkg::CfgIdxW-1:0] idx_i,
  input  wire logic [fmts_pkg::TickW-1:0]   wdata_i,
  output logic [fmts_pkg::BaseW-1:0]        status_base_o,
  output logic [fmts_pkg::TickW-1:0]        t1_tick_o,
  output logic [fmts_pkg::TickW-1:0]        t2_tick_o
);

  logic [fmts_pkg::BaseW-1:0] base_q;
  logic [fmts_pkg::TickW-1:0] t1_tick_q;
  logic [fmts_pkg::TickW-1:0] t2_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= fmts_pkg::StatusBaseRst;
      t1_tick_q <= fmts_pkg::T1TickRst;
      t2_tick_q <= fmts_pkg::T2TickRst;
    end else if (we_i) begin
      if (idx_i == fmts_pkg::CfgStatusBase) begin
        base_q <= wdata_i[fmts_pkg::BaseW-1:0];
      end
      if (idx_i == fmts_pkg::CfgT1Tick) begin
        t1_tick_q <= wdata_i;
      end
      if (idx_i == fmts_pkg::CfgT2Tick) begin
        t2_tick_q <= wdata_i;
      end
    end
  end

  assign status_base_o = base_q;
  assign t1_tick_o     = t1_tick_q;
  assign t2_tick_o     = t2_tick_q;

endmodule
`default_nettype wire

@@ hdl/fmts_timer.sv @@
// One interval timer: preset, enable, saturating elapsed count and expiry compare.
`default_nettype none
module fmts_timer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fmts_pkg::tmr_cmd_t       cmd_i,
  input  wire logic [fmts_pkg::TickW-1:0] tick_us_i,
  output logic                          expired_o
);

  logic [fmts_pkg::DataW-1:0]    preset_q, preset_d;
  logic                          en_q, en_d;
  logic [fmts_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [8:0]                    span;
  logic [fmts_pkg::LimitW-1:0]   limit;

  always_comb begin
    preset_d  = preset_q;
    en_d      = en_q;
    elapsed_d = elapsed_q;
    priority if (cmd_i.load) begin
      preset_d = cmd_i.preset;
      if (en_q) elapsed_d = '0;
    end else if (cmd_i.set_en) begin
      en_d = cmd_i.en;
      if (cmd_i.en) elapsed_d = '0;
    end else if (cmd_i.tick) begin
      // hold at the top instead of wrapping
      if (elapsed_q != fmts_pkg::ElapsedMax) elapsed_d = elapsed_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q  <= '0;
      en_q      <= 1'b0;
      elapsed_q <= '0;
    end else begin
      preset_q  <= preset_d;
      en_q      <= en_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign span      = fmts_pkg::PresetSpan - {1'b0, preset_q};
  assign limit     = {{(fmts_pkg::LimitW-9){1'b0}}, span} *
                     {{(fmts_pkg::LimitW-fmts_pkg::TickW){1'b0}}, tick_us_i};
  assign expired_o = en_q & ({1'b0, elapsed_q} > limit);

endmodule
`default_nettype wire

@@ hdl/fm_chip_dual_timer_status_core.sv @@
// Top level of the FM-chip dual timer and status port.
// Takes one item per clock while in_stall_o is low: register writes, status
// reads and microsecond ticks. Each item is registered on transfer and decoded
// from that register against the timer state, and a status read places its
// byte in the output register, from which it is presented. The per-timer
// multiply of (256 - preset) by the tick period and the elapsed compare set
// the cycle path.
// Configuration writes are always ready and take effect on the next clock.
`default_nettype none
module fm_chip_dual_timer_status_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [fmts_pkg::FuncW-1:0]   func_i,
  input  wire logic [fmts_pkg::AddrW-1:0]   reg_addr_i,
  input  wire logic [fmts_pkg::DataW-1:0]   wdata_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [fmts_pkg::DataW-1:0]        status_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [fmts_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fmts_pkg::TickW-1:0]   cfg_wdata_i
);

  logic                       s1_valid;
  fmts_pkg::item_t            s1_item;
  logic                       is_read, is_write, is_tick;
  logic                       take, fire;
  logic                       ctl_wr;
  fmts_pkg::tmr_cmd_t         t1_cmd, t2_cmd;
  logic                       t1_exp, t2_exp;
  logic [fmts_pkg::BaseW-1:0] status_base;
  logic [fmts_pkg::TickW-1:0] t1_tick, t2_tick;
  logic                       out_valid_q, out_valid_d;
  logic [fmts_pkg::DataW-1:0] status_q, status_d;

  assign cfg_ready_o = 1'b1;

  fmts_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (cfg_valid_i),
    .idx_i         (cfg_index_i),
    .wdata_i       (cfg_wdata_i),
    .status_base_o (status_base),
    .t1_tick_o     (t1_tick),
    .t2_tick_o     (t2_tick)
  );

  fmts_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .reg_addr_i (reg_addr_i),
    .wdata_i    (wdata_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  assign is_write = s1_item.func == fmts_pkg::FuncWrite;
  assign is_read  = s1_item.func == fmts_pkg::FuncRead;
  assign is_tick  = s1_item.func == fmts_pkg::FuncTick;

  // a read waits only while the output register still holds an untaken status
  assign take = ~is_read | ~out_valid_q | ~out_stall_i;
  assign fire = s1_valid & take;

  assign ctl_wr = fire & is_write & (s1_item.addr == fmts_pkg::RegControl);

  always_comb begin
    t1_cmd.tick   = fire & is_tick;
    t1_cmd.load   = fire & is_write & (s1_item.addr == fmts_pkg::RegT1Preset);
    t1_cmd.preset = s1_item.wdata;
    t1_cmd.set_en = ctl_wr & (s1_item.wdata[fmts_pkg::CtlIrqReset] |
                              ~s1_item.wdata[fmts_pkg::CtlT1Mask]);
    t1_cmd.en     = ~s1_item.wdata[fmts_pkg::CtlIrqReset] &
                    s1_item.wdata[fmts_pkg::CtlT1Start];

    t2_cmd.tick   = fire & is_tick;
    t2_cmd.load   = fire & is_write & (s1_item.addr == fmts_pkg::RegT2Preset);
    t2_cmd.preset = s1_item.wdata;
    t2_cmd.set_en = ctl_wr & (s1_item.wdata[fmts_pkg::CtlIrqReset] |
                              ~s1_item.wdata[fmts_pkg::CtlT2Mask]);
    t2_cmd.en     = ~s1_item.wdata[fmts_pkg::CtlIrqReset] &
                    s1_item.wdata[fmts_pkg::CtlT2Start];
  end

  fmts_timer u_t1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (t1_cmd),
    .tick_us_i (t1_tick),
    .expired_o (t1_exp)
  );

  fmts_timer u_t2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (t2_cmd),
    .tick_us_i (t2_tick),
    .expired_o (t2_exp)
  );

  assign status_d = {t1_exp | t2_exp, t1_exp, t2_exp, 2'b00, status_base};

  always_comb begin
    priority if (fire & is_read) out_valid_d = 1'b1;
    else if (!out_stall_i)       out_valid_d = 1'b0;
    else                         out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire & is_read) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire
